// ===== sv/range_max_segment_tree_top_defines.svh =====
// Assertion macros used by the range-max segment tree engine (rmst_engine).
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef RANGE_MAX_SEGMENT_TREE_TOP_DEFINES_SVH
`define RANGE_MAX_SEGMENT_TREE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RMST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RMST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMST_ASSERT(lbl, clk, rstn, prop, msg)
`define RMST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/rmst_pkg.sv =====
// Types, constants and helpers for the range-max segment tree.
// No dependencies; used by rmst_engine and range_max_segment_tree_top.
`timescale 1ns / 1ps

package rmst_pkg;

  localparam int unsigned LEAF_BITS   = 10;
  localparam int unsigned INDEX_W     = 10;
  localparam int unsigned IN_VALUE_W  = 32;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned RES_W       = 31;
  localparam int unsigned NODE_W      = LEAF_BITS + 1;
  localparam int unsigned WALK_W      = LEAF_BITS + 2;
  localparam int unsigned ROW_W       = LEAF_BITS;
  localparam int unsigned ROW_DATA_W  = 2 * VALUE_W;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef logic [INDEX_W-1:0]           index_t;
  typedef logic [NODE_W-1:0]            node_t;
  typedef logic [WALK_W-1:0]            walk_t;
  typedef logic [ROW_W-1:0]             row_addr_t;
  typedef logic [ROW_DATA_W-1:0]        row_data_t;
  typedef logic signed [VALUE_W-1:0]    value_t;
  typedef logic signed [IN_VALUE_W-1:0] in_value_t;

  typedef enum logic [0:0] {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QRY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [RES_W-1:0] value;
  } result_t;

  function automatic value_t max_val(value_t a, value_t b);
    return (a > b) ? a : b;
  endfunction

  // Row r holds node 2r in the low half and node 2r+1 in the high half.
  function automatic value_t node_of(row_data_t row, logic odd);
    return odd ? value_t'(row[ROW_DATA_W-1:VALUE_W]) : value_t'(row[VALUE_W-1:0]);
  endfunction

  function automatic value_t to_stored(in_value_t raw);
    return value_t'(raw);
  endfunction

endpackage

// ===== sv/rmst_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module rmst_ram #(
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 64
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== sv/rmst_engine.sv =====
// Tree walker: clear pass, leaf update with ancestor recompute, range query.
// Depends on rmst_pkg and drives an rmst_ram holding sibling pairs per row.
`timescale 1ns / 1ps
`include "range_max_segment_tree_top_defines.svh"

module rmst_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rmst_pkg::cmd_e     in_cmd_i,
  input  rmst_pkg::index_t   in_first_i,
  input  rmst_pkg::index_t   in_last_i,
  input  rmst_pkg::in_value_t in_value_i,
  output rmst_pkg::result_t  res_o,
  input  logic               res_ready_i,
  output logic               ram_we_o,
  output rmst_pkg::row_addr_t ram_waddr_o,
  output rmst_pkg::row_data_t ram_wdata_o,
  output rmst_pkg::row_addr_t ram_raddr_a_o,
  output rmst_pkg::row_addr_t ram_raddr_b_o,
  input  rmst_pkg::row_data_t ram_rdata_a_i,
  input  rmst_pkg::row_data_t ram_rdata_b_i
);

  import rmst_pkg::*;

  state_e    state_q, state_d;
  row_addr_t clr_q, clr_d;
  node_t     p_q, p_d;
  value_t    carry_q, carry_d;
  walk_t     a_q, a_d, b_q, b_d;
  value_t    best_q, best_d;

  logic      accept;
  index_t    first_leaf, last_leaf;
  row_data_t upd_row;
  value_t    upd_max;
  value_t    best1, best2;
  walk_t     a_inc, b_dec, a_nxt, b_nxt;

  assign accept     = in_valid_i && in_ready_o;
  assign first_leaf = in_first_i;
  assign last_leaf  = in_last_i;

  always_comb begin
    upd_row = ram_rdata_a_i;
    if (p_q[0]) begin
      upd_row[ROW_DATA_W-1:VALUE_W] = carry_q;
    end else begin
      upd_row[VALUE_W-1:0] = carry_q;
    end
    upd_max = max_val(node_of(upd_row, 1'b0), node_of(upd_row, 1'b1));
  end

  always_comb begin
    best1 = a_q[0] ? max_val(best_q, node_of(ram_rdata_a_i, a_q[0])) : best_q;
    best2 = !b_q[0] ? max_val(best1, node_of(ram_rdata_b_i, b_q[0])) : best1;
    a_inc = a_q + walk_t'(a_q[0]);
    b_dec = b_q - walk_t'(!b_q[0]);
    a_nxt = a_inc >> 1;
    b_nxt = b_dec >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    carry_q <= carry_d;
    a_q     <= a_d;
    b_q     <= b_d;
    best_q  <= best_d;
  end

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    p_d           = p_q;
    carry_d       = carry_q;
    a_d           = a_q;
    b_d           = b_q;
    best_d        = best_q;
    in_ready_o    = 1'b0;
    res_o.valid   = 1'b0;
    res_o.value   = best_q[RES_W-1:0];
    ram_we_o      = 1'b0;
    ram_waddr_o   = clr_q;
    ram_wdata_o   = '0;
    ram_raddr_a_o = {1'b1, first_leaf[LEAF_BITS-1:1]};
    ram_raddr_b_o = {1'b1, last_leaf[LEAF_BITS-1:1]};
    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o = 1'b1;
        clr_d    = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (in_cmd_i == CMD_UPDATE) begin
            p_d     = {1'b1, first_leaf[LEAF_BITS-1:0]};
            carry_d = to_stored(in_value_i);
            state_d = ST_UPD;
          end else begin
            a_d    = {2'b01, first_leaf[LEAF_BITS-1:0]};
            b_d    = {2'b01, last_leaf[LEAF_BITS-1:0]};
            best_d = '0;
            if (first_leaf > last_leaf) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_QRY;
            end
          end
        end
      end
      ST_UPD: begin
        ram_we_o      = 1'b1;
        ram_waddr_o   = p_q[NODE_W-1:1];
        ram_wdata_o   = upd_row;
        ram_raddr_a_o = row_addr_t'(p_q[NODE_W-1:2]);
        p_d           = p_q >> 1;
        carry_d       = upd_max;
        if (p_q == node_t'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_QRY: begin
        ram_raddr_a_o = a_nxt[ROW_W:1];
        ram_raddr_b_o = b_nxt[ROW_W:1];
        a_d           = a_nxt;
        b_d           = b_nxt;
        best_d        = best2;
        if (a_nxt > b_nxt) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `RMST_ASSERT(a_no_write_in_query, clk_i, rst_ni, (state_q == ST_QRY) |-> !ram_we_o, "write during query walk")
  `RMST_ASSERT(a_walk_order, clk_i, rst_ni, (state_q == ST_QRY) |-> (a_q <= b_q), "query walk crossed")
  `RMST_ASSERT(a_upd_node, clk_i, rst_ni, (state_q == ST_UPD) |-> (p_q != '0), "update walked past root")
  `RMST_ASSERT(a_done_source, clk_i, rst_ni, $rose(state_q == ST_DONE) |-> ($past(state_q) == ST_QRY || $past(state_q) == ST_IDLE), "result without query")

endmodule

// ===== sv/range_max_segment_tree_top.sv =====
// Range-max segment tree: 1024 leaves of signed 32-bit values, max over closed ranges.
// Update: the accept in ST_IDLE, then one ST_UPD step per tree level (11 levels), leaf to root.
// Query: the accept in ST_IDLE, one ST_QRY step per level walked (at most 11, two nodes read per step
// from the dual-read RAM), then ST_DONE holds the result until the output register takes it.
// Reset: a clearing pass zeroes the 1024 sibling-pair rows, with s_axis_tready low throughout.
// Depends on rmst_pkg, rmst_ram and rmst_engine.
`timescale 1ns / 1ps

module range_max_segment_tree_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] first_index, [19:10] last_index, [51:20] new_value, [55:52] zero
  input  logic [rmst_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [0] command
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [30:0] range_maximum, [31] zero
  output logic [rmst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  import rmst_pkg::*;

  result_t   res;
  logic      res_ready;
  logic      out_valid_q;
  logic [RES_W-1:0] out_data_q;

  logic      ram_we;
  row_addr_t ram_waddr, ram_raddr_a, ram_raddr_b;
  row_data_t ram_wdata, ram_rdata_a, ram_rdata_b;

  cmd_e      in_cmd;
  assign in_cmd = cmd_e'(s_axis_tuser);

  rmst_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_cmd_i      (in_cmd),
    .in_first_i    (s_axis_tdata[INDEX_W-1:0]),
    .in_last_i     (s_axis_tdata[2*INDEX_W-1:INDEX_W]),
    .in_value_i    (s_axis_tdata[2*INDEX_W+IN_VALUE_W-1:2*INDEX_W]),
    .res_o         (res),
    .res_ready_i   (res_ready),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_a_o (ram_raddr_a),
    .ram_raddr_b_o (ram_raddr_b),
    .ram_rdata_a_i (ram_rdata_a),
    .ram_rdata_b_i (ram_rdata_b)
  );

  rmst_ram #(
    .ADDR_W (ROW_W),
    .DATA_W (ROW_DATA_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_data_q <= res.value;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out_data_q};

endmodule
